/* rtl/llsa_pkg.sv */
// Shared types, codes and helpers of the lowest-loss sub-band allocator.
`default_nettype none

package llsa_pkg;

   // Geometry and field widths.
   localparam int MAX_BANDS_DEFAULT = 16;
   localparam int RESULT_LIMIT      = 16;
   localparam int THRESHOLD_W       = 11;
   localparam int BANDS_IN_USE_W    = 5;
   localparam int CSR_DATA_W        = 11;
   localparam int CSR_INDEX_W       = 1;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LOSS_THRESHOLD = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANDS_IN_USE   = 1'b1;

   // Register reset values.
   localparam logic [THRESHOLD_W-1:0]    LOSS_THRESHOLD_RESET = 11'd160;
   localparam logic [BANDS_IN_USE_W-1:0] BANDS_IN_USE_RESET   = 5'd10;

   // Request types.
   localparam logic [1:0] REQ_SET_LOSS = 2'd0;
   localparam logic [1:0] REQ_ALLOCATE = 2'd1;
   localparam logic [1:0] REQ_RELEASE  = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NO_BAND = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] user_id;
      logic [3:0]  band_select;
      logic [11:0] loss_value;
      logic [4:0]  bands_wanted;
   } req_item_type;

   typedef struct packed {
      logic [3:0] granted_band;
      logic [4:0] done_count;
      logic [4:0] busy_count;
      logic [1:0] status;
      logic       last;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SURVEY,
      ST_DECIDE,
      ST_SEARCH,
      ST_GRANT
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic survey;
      logic emit_single;
      logic search_start;
      logic search;
      logic grant;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic need_grants;
      logic grants_last;
   } dpath_status_type;

   // Saturate a count to the 5-bit result fields.
   function automatic logic [4:0] sat5(input logic [31:0] value);
      logic [4:0] result;
      result = (value > 32'd31) ? 5'd31 : value[4:0];
      return result;
   endfunction

endpackage

`default_nettype wire

/* rtl/llsa_ctrl.sv */
// Controller state machine of the sub-band allocator.
`default_nettype none

module llsa_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire llsa_pkg::dpath_status_type stat,
   output llsa_pkg::ctrl_cmd_type          cmd
);

   llsa_pkg::ctrl_state_type state_ff;
   llsa_pkg::ctrl_state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         llsa_pkg::ST_IDLE: begin
            if (start) state_in = llsa_pkg::ST_SURVEY;
         end
         llsa_pkg::ST_SURVEY: begin
            if (stat.scan_last) state_in = llsa_pkg::ST_DECIDE;
         end
         llsa_pkg::ST_DECIDE: begin
            state_in = stat.need_grants ? llsa_pkg::ST_SEARCH : llsa_pkg::ST_IDLE;
         end
         llsa_pkg::ST_SEARCH: begin
            if (stat.scan_last) state_in = llsa_pkg::ST_GRANT;
         end
         llsa_pkg::ST_GRANT: begin
            state_in = stat.grants_last ? llsa_pkg::ST_IDLE : llsa_pkg::ST_SEARCH;
         end
         default: begin
            state_in = llsa_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands for the datapath.
   always_comb begin
      cmd              = '0;
      cmd.load         = (state_ff == llsa_pkg::ST_IDLE) && start;
      cmd.survey       = (state_ff == llsa_pkg::ST_SURVEY);
      cmd.emit_single  = (state_ff == llsa_pkg::ST_DECIDE) && !stat.need_grants;
      cmd.search_start = (state_ff == llsa_pkg::ST_DECIDE) && stat.need_grants;
      cmd.search       = (state_ff == llsa_pkg::ST_SEARCH);
      cmd.grant        = (state_ff == llsa_pkg::ST_GRANT);
   end

   assign busy = (state_ff != llsa_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llsa_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/llsa_dpath.sv */
// Datapath of the sub-band allocator: band table, scan unit, counters and result register.
`default_nettype none

module llsa_dpath #(
   parameter int MAX_BANDS = llsa_pkg::MAX_BANDS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_write_enable,
   input  wire logic [llsa_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [llsa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  wire llsa_pkg::req_item_type              req_data,
   input  wire llsa_pkg::ctrl_cmd_type              cmd,
   output llsa_pkg::dpath_status_type               stat,
   output logic                                     rsp_strobe,
   output llsa_pkg::rsp_item_type                   rsp_data
);

   localparam int IW = $clog2(MAX_BANDS);
   localparam int CW = $clog2(MAX_BANDS + 1);

   // Configuration registers.
   logic [llsa_pkg::THRESHOLD_W-1:0]    thr_ff, thr_in;
   logic [llsa_pkg::BANDS_IN_USE_W-1:0] biu_ff, biu_in;

   // Band table.
   logic [11:0] loss_ff  [MAX_BANDS];
   logic [11:0] loss_in  [MAX_BANDS];
   logic [15:0] owner_ff [MAX_BANDS];
   logic [15:0] owner_in [MAX_BANDS];

   // Request and scan state.
   llsa_pkg::req_item_type req_ff, req_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] busy_ff, busy_in;
   logic [CW-1:0] elig_ff, elig_in;
   logic [CW-1:0] freed_ff, freed_in;
   logic          found_ff, found_in;
   logic [11:0]   best_loss_ff, best_loss_in;
   logic [IW-1:0] best_idx_ff, best_idx_in;
   logic [4:0]    grants_ff, grants_in;
   logic [4:0]    granted_ff, granted_in;

   // Result register.
   llsa_pkg::rsp_item_type rsp_ff, rsp_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;

   // Derived values.
   logic [CW-1:0] act_n;
   logic [IW-1:0] cur_idx;
   logic [IW-1:0] sel_idx;
   logic          in_range;
   logic [15:0]   cur_owner;
   logic [11:0]   cur_loss;
   logic          cur_free_ok;
   logic          rel_valid;
   logic          cur_match;
   logic          user_ok;
   logic          sel_ok;
   logic [4:0]    grants_calc;
   logic [31:0]   grants_wide;
   logic [1:0]    single_status;
   logic [4:0]    single_done;

   // Active band count is the smaller of the register and the table depth.
   always_comb begin
      if (32'(biu_ff) < 32'(MAX_BANDS)) begin
         act_n = CW'(biu_ff);
      end else begin
         act_n = CW'(MAX_BANDS);
      end
   end

   // Entry under the scan pointer.
   assign cur_idx     = idx_ff[IW-1:0];
   assign in_range    = (idx_ff < act_n);
   assign cur_owner   = owner_ff[cur_idx];
   assign cur_loss    = loss_ff[cur_idx];
   assign cur_free_ok = (cur_owner == 16'd0) && (cur_loss <= {1'b0, thr_ff});
   assign rel_valid   = (req_ff.req_type == llsa_pkg::REQ_RELEASE) && user_ok;
   assign cur_match   = rel_valid && (cur_owner == req_ff.user_id);

   // Request checks.
   assign user_ok = (req_ff.user_id != 16'd0);
   assign sel_ok  = (32'(req_ff.band_select) < 32'(act_n));
   assign sel_idx = IW'(req_ff.band_select);

   // Grants are bounded by the wish, the eligible bands and the result limit.
   always_comb begin
      grants_wide = 32'(req_ff.bands_wanted);
      if (grants_wide > 32'(elig_ff)) grants_wide = 32'(elig_ff);
      if (grants_wide > 32'(llsa_pkg::RESULT_LIMIT)) begin
         grants_wide = 32'(llsa_pkg::RESULT_LIMIT);
      end
      grants_calc = grants_wide[4:0];
   end

   // Outcome of a request that gives one result.
   always_comb begin
      single_done = 5'd0;
      unique case (req_ff.req_type)
         llsa_pkg::REQ_SET_LOSS: begin
            single_status = sel_ok ? llsa_pkg::STATUS_OK : llsa_pkg::STATUS_INVALID;
         end
         llsa_pkg::REQ_ALLOCATE: begin
            if (!user_ok) begin
               single_status = llsa_pkg::STATUS_INVALID;
            end else if (elig_ff == '0) begin
               single_status = llsa_pkg::STATUS_NO_BAND;
            end else begin
               single_status = llsa_pkg::STATUS_OK;
            end
         end
         llsa_pkg::REQ_RELEASE: begin
            single_status = user_ok ? llsa_pkg::STATUS_OK : llsa_pkg::STATUS_INVALID;
            if (user_ok) single_done = llsa_pkg::sat5(32'(freed_ff));
         end
         default: begin
            single_status = llsa_pkg::STATUS_INVALID;
         end
      endcase
   end

   // Status for the controller.
   always_comb begin
      stat.scan_last   = ({1'b0, idx_ff} + 1'b1) >= {1'b0, act_n};
      stat.need_grants = (req_ff.req_type == llsa_pkg::REQ_ALLOCATE) && user_ok
                         && (elig_ff != '0) && (grants_calc != 5'd0);
      stat.grants_last = ((granted_ff + 5'd1) == grants_ff);
   end

   // Next values of all registers.
   always_comb begin
      thr_in        = thr_ff;
      biu_in        = biu_ff;
      loss_in       = loss_ff;
      owner_in      = owner_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      busy_in       = busy_ff;
      elig_in       = elig_ff;
      freed_in      = freed_ff;
      found_in      = found_ff;
      best_loss_in  = best_loss_ff;
      best_idx_in   = best_idx_ff;
      grants_in     = grants_ff;
      granted_in    = granted_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;

      // Configuration writes.
      if (csr_write_enable && (csr_index == llsa_pkg::CSR_LOSS_THRESHOLD)) begin
         thr_in = csr_write_data[llsa_pkg::THRESHOLD_W-1:0];
      end
      if (csr_write_enable && (csr_index == llsa_pkg::CSR_BANDS_IN_USE)) begin
         biu_in = csr_write_data[llsa_pkg::BANDS_IN_USE_W-1:0];
      end

      // Capture a new request and clear the survey counters.
      if (cmd.load) begin
         req_in   = req_data;
         idx_in   = '0;
         busy_in  = '0;
         elig_in  = '0;
         freed_in = '0;
      end

      // Survey pass: count busy and eligible bands, free a released user's bands.
      if (cmd.survey) begin
         if (in_range) begin
            if (cur_match) begin
               owner_in[cur_idx] = 16'd0;
               freed_in          = freed_ff + 1'b1;
            end
            if ((cur_owner != 16'd0) && !cur_match) busy_in = busy_ff + 1'b1;
            if (cur_free_ok) elig_in = elig_ff + 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end

      // Single result; a valid set-loss writes its band here.
      if (cmd.emit_single) begin
         if ((req_ff.req_type == llsa_pkg::REQ_SET_LOSS) && sel_ok) begin
            loss_in[sel_idx] = req_ff.loss_value;
         end
         rsp_in.granted_band = 4'd0;
         rsp_in.done_count   = single_done;
         rsp_in.busy_count   = llsa_pkg::sat5(32'(busy_ff));
         rsp_in.status       = single_status;
         rsp_in.last         = 1'b1;
         rsp_strobe_in       = 1'b1;
      end

      // Set up the grant loop.
      if (cmd.search_start) begin
         idx_in     = '0;
         found_in   = 1'b0;
         grants_in  = grants_calc;
         granted_in = 5'd0;
      end

      // Minimum search: strict compare keeps the lower index on ties.
      if (cmd.search) begin
         if (in_range && cur_free_ok && (!found_ff || (cur_loss < best_loss_ff))) begin
            best_idx_in  = cur_idx;
            best_loss_in = cur_loss;
            found_in     = 1'b1;
         end
         idx_in = idx_ff + 1'b1;
      end

      // Grant the band found and report it.
      if (cmd.grant) begin
         owner_in[best_idx_ff] = req_ff.user_id;
         busy_in               = busy_ff + 1'b1;
         granted_in            = granted_ff + 5'd1;
         rsp_in.granted_band   = 4'(best_idx_ff);
         rsp_in.done_count     = granted_ff + 5'd1;
         rsp_in.busy_count     = llsa_pkg::sat5(32'(busy_ff) + 32'd1);
         rsp_in.status         = llsa_pkg::STATUS_OK;
         rsp_in.last           = stat.grants_last;
         rsp_strobe_in         = 1'b1;
         idx_in                = '0;
         found_in              = 1'b0;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff        <= llsa_pkg::LOSS_THRESHOLD_RESET;
         biu_ff        <= llsa_pkg::BANDS_IN_USE_RESET;
         for (int i = 0; i < MAX_BANDS; i++) begin
            loss_ff[i]  <= 12'd0;
            owner_ff[i] <= 16'd0;
         end
         rsp_strobe_ff <= 1'b0;
         found_ff      <= 1'b0;
         idx_ff        <= '0;
         busy_ff       <= '0;
         elig_ff       <= '0;
         freed_ff      <= '0;
         grants_ff     <= 5'd0;
         granted_ff    <= 5'd0;
      end else begin
         thr_ff        <= thr_in;
         biu_ff        <= biu_in;
         loss_ff       <= loss_in;
         owner_ff      <= owner_in;
         rsp_strobe_ff <= rsp_strobe_in;
         found_ff      <= found_in;
         idx_ff        <= idx_in;
         busy_ff       <= busy_in;
         elig_ff       <= elig_in;
         freed_ff      <= freed_in;
         grants_ff     <= grants_in;
         granted_ff    <= granted_in;
      end
      req_ff       <= req_in;
      best_loss_ff <= best_loss_in;
      best_idx_ff  <= best_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   // A grant always follows a search that found an eligible band.
   a_grant_found: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> found_ff)
      else $error("grant issued without a found band");

   // The band being granted is still free.
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> (owner_ff[best_idx_ff] == 16'd0))
      else $error("grant of a band that is already owned");

   // Each grant reports the running count of this request.
   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |=> (rsp_strobe_ff && (rsp_ff.done_count == granted_ff)))
      else $error("grant result count mismatch");

   // The grant loop never starts with nothing to grant.
   a_loop_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.search_start |=> (grants_ff != 5'd0) && (granted_ff == 5'd0))
      else $error("grant loop started with zero grants");
`endif

endmodule

`default_nettype wire

/* rtl/lowest_loss_subband_allocator.sv */
// Top level of the lowest-loss sub-band allocator.
//
// A request is taken when start is high and busy is low, and busy stays high until the
// request is finished. The band table is walked one entry per cycle. A set-loss, release or
// rejected request takes one survey pass that counts; an allocate granting g bands then
// takes one minimum-search pass per grant. Every result appears for exactly one cycle with
// rsp_strobe high, in the cycle after it is formed; the receiver must take it then, as the
// block cannot hold results back. Results of one request arrive in grant order with last set
// on the final one. Configuration writes land at once and belong in idle periods.
`default_nettype none

module lowest_loss_subband_allocator #(
   parameter int MAX_BANDS = llsa_pkg::MAX_BANDS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire llsa_pkg::req_item_type           req_data,
   output logic                                  rsp_strobe,
   output llsa_pkg::rsp_item_type                rsp_data,
   input  wire logic                             csr_write_enable,
   input  wire logic [llsa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [llsa_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   llsa_pkg::ctrl_cmd_type     cmd;
   llsa_pkg::dpath_status_type stat;

   // Sequencer.
   llsa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Table, scan unit and result register.
   llsa_dpath #(
      .MAX_BANDS (MAX_BANDS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_strobe       (rsp_strobe),
      .rsp_data         (rsp_data)
   );

endmodule

`default_nettype wire
